@@ hw/rtl/websocket_text_frame_decoder_defines.svh @@
// Assertion macros shared by the checker of the WebSocket text frame decoder.
// Depends on nothing; files that assert take it in by include.
`ifndef WEBSOCKET_TEXT_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_TEXT_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSTFD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WSTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/wstfd_pkg.sv @@
// Shared types and constants of the WebSocket text frame decoder.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package wstfd_pkg;

   // Result status codes.
   localparam logic [1:0] ST_PAYLOAD = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FRAG    = 2'd2;
   localparam logic [1:0] ST_OPCODE  = 2'd3;

   // Header field masks and codes.
   localparam logic [7:0] FIN_MASK    = 8'h80;
   localparam logic [7:0] OPCODE_MASK = 8'h0F;
   localparam logic [7:0] LEN7_MASK   = 8'h7F;
   localparam logic [7:0] OPCODE_TEXT = 8'h01;
   localparam logic [7:0] LEN_EXT16   = 8'd126;
   localparam logic [7:0] LEN_EXT64   = 8'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   // Queue between front and back.
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
   localparam int QUEUE_CW    = QUEUE_AW + 1;
   localparam logic [QUEUE_CW-1:0] QUEUE_FULL_COUNT = QUEUE_CW'(QUEUE_DEPTH);

   // Parser phases, one-hot.
   typedef enum logic [4:0] {
      PH_HDR0 = 5'b00001,
      PH_HDR1 = 5'b00010,
      PH_EXT  = 5'b00100,
      PH_KEY  = 5'b01000,
      PH_DATA = 5'b10000
   } phase_type;

   // One classified result waiting for the back end.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic [7:0] key;
      logic       last;
   } entry_type;

   // Front to queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Queue to back.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

@@ hw/rtl/wstfd_front.sv @@
// Front end of the WebSocket text frame decoder: header parser and classifier.
// Depends on wstfd_pkg.
`timescale 1ns / 1ps

module wstfd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [7:0]           req_stream_byte,
   output wstfd_pkg::push_type  push
);

   wstfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic        masked_ff, masked_in;
   logic [63:0] frame_len_ff, frame_len_in;
   logic [31:0] key_ff, key_in;
   logic [2:0]  key_left_ff, key_left_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [1:0]  lane_ff, lane_in;

   logic        accept;
   logic [7:0]  b;
   logic [63:0] len_new;
   logic [63:0] rem_dec;
   logic [3:0]  ext_dec;
   logic [2:0]  key_dec;
   logic [7:0]  key_byte;

   assign accept  = req_valid && !req_stall;
   assign b       = req_stream_byte;
   assign rem_dec = remaining_ff - 64'd1;
   assign ext_dec = ext_left_ff - 4'd1;
   assign key_dec = key_left_ff - 3'd1;

   always_comb begin
      case (lane_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      ext_left_in  = ext_left_ff;
      masked_in    = masked_ff;
      frame_len_in = frame_len_ff;
      key_in       = key_ff;
      key_left_in  = key_left_ff;
      remaining_in = remaining_ff;
      lane_in      = lane_ff;
      len_new      = frame_len_ff;
      push         = '0;
      if (accept) begin
         case (phase_ff)
            wstfd_pkg::PH_HDR1: begin
               masked_in    = (b & wstfd_pkg::FIN_MASK) != 8'd0;
               frame_len_in = '0;
               if ((b & wstfd_pkg::LEN7_MASK) == wstfd_pkg::LEN_EXT16) begin
                  ext_left_in = wstfd_pkg::EXT16_BYTES;
                  phase_in    = wstfd_pkg::PH_EXT;
               end else if ((b & wstfd_pkg::LEN7_MASK) == wstfd_pkg::LEN_EXT64) begin
                  ext_left_in = wstfd_pkg::EXT64_BYTES;
                  phase_in    = wstfd_pkg::PH_EXT;
               end else begin
                  len_new      = {56'd0, b & wstfd_pkg::LEN7_MASK};
                  frame_len_in = len_new;
                  if (masked_in) begin
                     key_in      = '0;
                     key_left_in = wstfd_pkg::KEY_BYTES;
                     phase_in    = wstfd_pkg::PH_KEY;
                  end else if (len_new == 64'd0) begin
                     phase_in           = wstfd_pkg::PH_HDR0;
                     push.valid         = 1'b1;
                     push.entry.status  = wstfd_pkg::ST_EMPTY;
                     push.entry.last    = 1'b1;
                  end else begin
                     remaining_in = len_new;
                     lane_in      = 2'd0;
                     phase_in     = wstfd_pkg::PH_DATA;
                  end
               end
            end
            wstfd_pkg::PH_EXT: begin
               len_new      = {frame_len_ff[55:0], b};
               frame_len_in = len_new;
               ext_left_in  = ext_dec;
               if (ext_dec == 4'd0) begin
                  if (masked_ff) begin
                     key_in      = '0;
                     key_left_in = wstfd_pkg::KEY_BYTES;
                     phase_in    = wstfd_pkg::PH_KEY;
                  end else if (len_new == 64'd0) begin
                     phase_in           = wstfd_pkg::PH_HDR0;
                     push.valid         = 1'b1;
                     push.entry.status  = wstfd_pkg::ST_EMPTY;
                     push.entry.last    = 1'b1;
                  end else begin
                     remaining_in = len_new;
                     lane_in      = 2'd0;
                     phase_in     = wstfd_pkg::PH_DATA;
                  end
               end
            end
            wstfd_pkg::PH_KEY: begin
               key_in      = {key_ff[23:0], b};
               key_left_in = key_dec;
               if (key_dec == 3'd0) begin
                  if (frame_len_ff == 64'd0) begin
                     phase_in           = wstfd_pkg::PH_HDR0;
                     push.valid         = 1'b1;
                     push.entry.status  = wstfd_pkg::ST_EMPTY;
                     push.entry.last    = 1'b1;
                  end else begin
                     remaining_in = frame_len_ff;
                     lane_in      = 2'd0;
                     phase_in     = wstfd_pkg::PH_DATA;
                  end
               end
            end
            wstfd_pkg::PH_DATA: begin
               lane_in           = lane_ff + 2'd1;
               remaining_in      = rem_dec;
               push.valid        = 1'b1;
               push.entry.status = wstfd_pkg::ST_PAYLOAD;
               push.entry.data   = b;
               push.entry.key    = masked_ff ? key_byte : 8'd0;
               push.entry.last   = rem_dec == 64'd0;
               if (rem_dec == 64'd0) begin
                  phase_in = wstfd_pkg::PH_HDR0;
               end
            end
            default: begin
               // First header byte: FIN is checked before the opcode.
               if ((b & wstfd_pkg::FIN_MASK) == 8'd0) begin
                  phase_in          = wstfd_pkg::PH_HDR0;
                  push.valid        = 1'b1;
                  push.entry.status = wstfd_pkg::ST_FRAG;
                  push.entry.last   = 1'b1;
               end else if ((b & wstfd_pkg::OPCODE_MASK) != wstfd_pkg::OPCODE_TEXT) begin
                  phase_in          = wstfd_pkg::PH_HDR0;
                  push.valid        = 1'b1;
                  push.entry.status = wstfd_pkg::ST_OPCODE;
                  push.entry.last   = 1'b1;
               end else begin
                  phase_in = wstfd_pkg::PH_HDR1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wstfd_pkg::PH_HDR0;
         ext_left_ff <= '0;
         masked_ff   <= 1'b0;
         key_left_ff <= '0;
         lane_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         masked_ff   <= masked_in;
         key_left_ff <= key_left_in;
         lane_ff     <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_len_ff <= frame_len_in;
      key_ff       <= key_in;
      remaining_ff <= remaining_in;
   end

endmodule

@@ hw/rtl/wstfd_queue.sv @@
// Short queue of classified results between front and back end.
// Depends on wstfd_pkg.
`timescale 1ns / 1ps

module wstfd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  wstfd_pkg::push_type  push,
   input  logic                 pop,
   output logic                 full,
   output wstfd_pkg::head_type  head
);

   wstfd_pkg::entry_type mem_ff [wstfd_pkg::QUEUE_DEPTH];
   logic [wstfd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [wstfd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [wstfd_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full       = count_ff == wstfd_pkg::QUEUE_FULL_COUNT;
   assign head.valid = count_ff != '0;
   assign head.entry = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

@@ hw/rtl/wstfd_back.sv @@
// Back end of the WebSocket text frame decoder: unmasking and output register.
// Depends on wstfd_pkg.
`timescale 1ns / 1ps

module wstfd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  wstfd_pkg::head_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_payload_byte,
   output logic                 rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] status_ff;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Output register loads a waiting entry when empty or when its transfer completes.
   assign pop      = head.valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= head.entry.status;
         byte_ff   <= head.entry.data ^ head.entry.key;
         last_ff   <= head.entry.last;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last         = last_ff;

endmodule

@@ hw/rtl/websocket_text_frame_decoder.sv @@
// WebSocket text frame decoder, top level. Accepts one stream byte per cycle unless stalled.
// A result passes through the queue and the output register before it shows on rsp.
// Throughput: one byte per cycle while req_stall is low. Header bytes give a result only
// for empty messages and errors; a 4-entry queue absorbs rsp stalls before req stalls.
// Reset is synchronous and active high; it returns the parser to the first header byte.
// Depends on wstfd_pkg, wstfd_front, wstfd_queue and wstfd_back.
`timescale 1ns / 1ps

module websocket_text_frame_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last
);

   // The front end walks the frame header one byte at a time. Each byte that
   // produces a result (a payload byte, an empty message or a header error) is
   // classified there and written to the queue together with its mask key byte.
   wstfd_pkg::push_type push;
   wstfd_pkg::head_type head;
   logic                queue_full;
   logic                pop;

   // The front end stalls whenever the queue is full, so a result waiting on the
   // rsp side can block bytes that produce no result as well.
   assign req_stall = queue_full;

   wstfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_stream_byte (req_stream_byte),
      .push            (push)
   );

   // The queue decouples the parser from the output side; each part stalls on
   // its own.
   wstfd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // The back end applies the mask key and holds the result in the output
   // register until its transfer completes.
   wstfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

endmodule

@@ hw/rtl/wstfd_checker.sv @@
// Port-level checker of the WebSocket text frame decoder and its bind.
// Depends on wstfd_pkg and websocket_text_frame_decoder_defines.svh.
`timescale 1ns / 1ps
`include "websocket_text_frame_decoder_defines.svh"

module wstfd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last
);

   `WSTFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp valid dropped while stalled")
   `WSTFD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_payload_byte) && $stable(rsp_last), "rsp payload changed while stalled")
   `WSTFD_ASSERT_NOW(a_status_shape, clock, reset, rsp_valid && rsp_status != wstfd_pkg::ST_PAYLOAD, rsp_last && rsp_payload_byte == 8'd0, "non-payload result without last or with data")

endmodule

bind websocket_text_frame_decoder wstfd_checker u_checker (.*);

@@ tb/websocket_text_frame_decoder_tb.sv @@
// Self-checking testbench for the WebSocket text frame decoder: directed and random byte streams.
// The scoreboard class tracks the frame parser state and checks every rsp transfer in order.
// Depends on wstfd_pkg and websocket_text_frame_decoder.
`timescale 1ns / 1ps

module websocket_text_frame_decoder_tb;

   // Least number of random stream bytes sent after the directed opening.
   localparam int RANDOM_BYTES = 780;
   // A byte's result passes the queue and the output register after its transfer, so a short drain is plenty.
   localparam int DRAIN_CYCLES = 12;
   localparam int SETTLE_LIMIT = 20000;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic       last;
   } frame_result_type;

   // The scoreboard keeps its own copy of the parser state. Every accepted stream byte
   // advances it and may queue one expected result; every rsp transfer is compared
   // with the oldest queued result.
   class frame_decode_board;
      wstfd_pkg::phase_type phase;
      logic [3:0]           ext_left;
      logic                 masked;
      logic [63:0]          frame_len;
      logic [31:0]          key;
      logic [2:0]           key_left;
      logic [63:0]          remaining;
      logic [1:0]           lane;
      frame_result_type     pending_results[$];
      int                   mismatches;
      int                   payload_seen;
      int                   empty_seen;
      int                   errors_seen;

      function new();
         phase        = wstfd_pkg::PH_HDR0;
         ext_left     = '0;
         masked       = 1'b0;
         frame_len    = '0;
         key          = '0;
         key_left     = '0;
         remaining    = '0;
         lane         = '0;
         mismatches   = 0;
         payload_seen = 0;
         empty_seen   = 0;
         errors_seen  = 0;
      endfunction

      function void push_result(logic [1:0] status, logic [7:0] data, logic last);
         frame_result_type r;
         r.status = status;
         r.data   = data;
         r.last   = last;
         pending_results.push_back(r);
      endfunction

      // The header is complete: either the payload starts or an empty message is reported.
      function void start_payload();
         if (frame_len == 64'd0) begin
            phase = wstfd_pkg::PH_HDR0;
            push_result(wstfd_pkg::ST_EMPTY, 8'h00, 1'b1);
         end else begin
            remaining = frame_len;
            lane      = '0;
            phase     = wstfd_pkg::PH_DATA;
         end
      endfunction

      // The length is known: a masked frame still has its key to come.
      function void length_known();
         if (masked) begin
            key      = '0;
            key_left = wstfd_pkg::KEY_BYTES;
            phase    = wstfd_pkg::PH_KEY;
         end else begin
            start_payload();
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] len7;
         logic [7:0] k;
         case (phase)
            wstfd_pkg::PH_HDR1: begin
               len7      = b & wstfd_pkg::LEN7_MASK;
               masked    = b[7];
               frame_len = '0;
               if (len7 == wstfd_pkg::LEN_EXT16) begin
                  ext_left = wstfd_pkg::EXT16_BYTES;
                  phase    = wstfd_pkg::PH_EXT;
               end else if (len7 == wstfd_pkg::LEN_EXT64) begin
                  ext_left = wstfd_pkg::EXT64_BYTES;
                  phase    = wstfd_pkg::PH_EXT;
               end else begin
                  frame_len = 64'(len7);
                  length_known();
               end
            end
            wstfd_pkg::PH_EXT: begin
               // Extended length arrives most significant byte first.
               frame_len = {frame_len[55:0], b};
               ext_left  = ext_left - 4'd1;
               if (ext_left == 4'd0) length_known();
            end
            wstfd_pkg::PH_KEY: begin
               // The first key byte ends up in the top byte of the key.
               key      = {key[23:0], b};
               key_left = key_left - 3'd1;
               if (key_left == 3'd0) start_payload();
            end
            wstfd_pkg::PH_DATA: begin
               k         = masked ? 8'(key >> (24 - 8 * int'(lane))) : 8'h00;
               lane      = lane + 2'd1;
               remaining = remaining - 64'd1;
               if (remaining == 64'd0) begin
                  phase = wstfd_pkg::PH_HDR0;
                  push_result(wstfd_pkg::ST_PAYLOAD, b ^ k, 1'b1);
               end else begin
                  push_result(wstfd_pkg::ST_PAYLOAD, b ^ k, 1'b0);
               end
            end
            default: begin
               // FIN takes priority over the opcode check.
               if ((b & wstfd_pkg::FIN_MASK) == 8'h00) begin
                  phase = wstfd_pkg::PH_HDR0;
                  push_result(wstfd_pkg::ST_FRAG, 8'h00, 1'b1);
               end else if ((b & wstfd_pkg::OPCODE_MASK) != wstfd_pkg::OPCODE_TEXT) begin
                  phase = wstfd_pkg::PH_HDR0;
                  push_result(wstfd_pkg::ST_OPCODE, 8'h00, 1'b1);
               end else begin
                  phase = wstfd_pkg::PH_HDR1;
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH at %0t ns: %s", $time, what);
      endtask

      task check_result(frame_result_type got);
         frame_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d data=%02h last=%0b",
                                      got.status, got.data, got.last));
         end else begin
            want = pending_results.pop_front();
            if (got.status != want.status)
               report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.data != want.data)
               report_mismatch($sformatf("payload byte %02h, expected %02h",
                                         got.data, want.data));
            if (got.last != want.last)
               report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
         end
         case (got.status)
            wstfd_pkg::ST_PAYLOAD: payload_seen++;
            wstfd_pkg::ST_EMPTY:   empty_seen++;
            default:               errors_seen++;
         endcase
      endtask
   endclass

   bit         clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_stream_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last;

   frame_decode_board board;
   int                bytes_sent;
   // While quiet is set neither side idles, so the block sees back-to-back transfers.
   bit                quiet;

   websocket_text_frame_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // Called at a falling edge. Holds valid for the whole transfer and returns at the
   // falling edge after it, leaving valid high so that a following byte can go at once.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   // A well-formed text frame with random reserved bits, mask, length form and content.
   // With huge set the 64-bit length has its top bit set; only a few payload bytes follow,
   // and the frame never ends.
   task automatic send_text_frame(input bit huge);
      logic [7:0]  hdr0;
      logic [7:0]  len7;
      logic [63:0] len;
      logic [31:0] key;
      bit          masked;
      int          ext_count;
      int          n;
      int          r;
      hdr0   = wstfd_pkg::FIN_MASK | wstfd_pkg::OPCODE_TEXT
               | {1'b0, 3'($urandom_range(0, 7)), 4'h0};
      masked = huge ? 1'b1 : 1'($urandom_range(0, 1));
      key    = $urandom;
      r      = $urandom_range(0, 9);
      if (huge) begin
         len       = {1'b1, 31'($urandom), 32'($urandom)};
         len7      = wstfd_pkg::LEN_EXT64;
         ext_count = 8;
      end else if (r < 6) begin
         len       = (r < 5) ? $urandom_range(0, 12) : $urandom_range(13, 125);
         len7      = len[7:0];
         ext_count = 0;
      end else if (r < 8) begin
         // Mostly lengths that would fit the short form, to cover non-minimal encodings.
         len       = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 700)
                                                 : $urandom_range(0, 40);
         len7      = wstfd_pkg::LEN_EXT16;
         ext_count = 2;
      end else begin
         len       = $urandom_range(0, 40);
         len7      = wstfd_pkg::LEN_EXT64;
         ext_count = 8;
      end
      send_byte(hdr0);
      send_byte({masked, len7[6:0]});
      for (int i = ext_count - 1; i >= 0; i--) send_byte(8'(len >> (8 * i)));
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(8'(key >> (8 * i)));
      end
      n = huge ? 24 : int'(len);
      for (int i = 0; i < n; i++) send_byte(8'($urandom));
   endtask

   // A first header byte that the block must reject: either FIN clear, or FIN set
   // with an opcode other than text.
   task automatic send_bad_header(input bit fin_clear);
      logic [7:0] op;
      op = 8'($urandom_range(0, 14));
      if (op >= wstfd_pkg::OPCODE_TEXT) op = op + 8'd1;
      if (fin_clear) send_byte(8'($urandom) & ~wstfd_pkg::FIN_MASK);
      else send_byte(wstfd_pkg::FIN_MASK | {1'b0, 3'($urandom_range(0, 7)), op[3:0]});
   endtask

   // Every rsp transfer is checked at the rising edge on which it happens.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{status: rsp_status, data: rsp_payload_byte, last: rsp_last});
   end

   // The receiver stalls in runs of random length, and not at all while quiet is set.
   initial begin : rsp_pacing
      int hold;
      int free;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = pick_gap();
         free = 1 + pick_gap();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (free) @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [7:0] opening [$];
      int         settle;
      int         r;
      board           = new();
      bytes_sent      = 0;
      quiet           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed opening. A byte with FIN clear and a non-text opcode must report the
      // fragment error. Then a bad opcode, empty messages that end on the second header
      // byte, on the last key byte and on the last extended length byte, and a short
      // masked frame whose key clears an all-ones payload byte and keeps an all-zeros one.
      opening = '{8'h00,
                  8'h8F,
                  8'h81, 8'h00,
                  8'h81, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78,
                  8'h81, 8'h7E, 8'h00, 8'h00,
                  8'h81, 8'h82, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h00};
      foreach (opening[i]) send_byte(opening[i]);

      // Random part: mostly well-formed frames, with rejected header bytes mixed in.
      while (bytes_sent < opening.size() + RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 5) == 0);
         r     = $urandom_range(0, 99);
         if (r < 80) send_text_frame(1'b0);
         else send_bad_header(r < 90);
      end
      quiet = 1'b0;

      // A frame with the top bit of its 64-bit length set closes the stream.
      send_text_frame(1'b1);
      req_valid <= 1'b0;

      settle = 0;
      while (board.pending_results.size() != 0 && settle < SETTLE_LIMIT) begin
         @(negedge clock);
         settle++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.pending_results.size() != 0)
         board.report_mismatch($sformatf("%0d expected results never arrived",
                                         board.pending_results.size()));

      $display("Run covered %0d stream bytes and checked %0d payload bytes,",
               bytes_sent, board.payload_seen);
      $display("%0d empty messages and %0d header errors; %0d mismatches.",
               board.empty_seen, board.errors_seen, board.mismatches);
      if (board.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: far longer than the slowest correct run needs.
   initial begin : watchdog
      #1000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/wstfd_pkg.sv
hw/rtl/wstfd_front.sv
hw/rtl/wstfd_queue.sv
hw/rtl/wstfd_back.sv
hw/rtl/websocket_text_frame_decoder.sv
hw/rtl/wstfd_checker.sv
tb/websocket_text_frame_decoder_tb.sv
